// ===== sv/rasm_pkg.sv =====
// Package with types, constants and helper functions for the RC arming sequencer and mixer.
package rasm_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 88;

    localparam int ELAPSED_W = 10;
    localparam int STICK_W   = 7;
    localparam int HOLD_W    = 16;
    localparam int PULSE_W   = 12;
    localparam int GAIN_W    = 6;
    localparam int MIX_W     = 9;
    localparam int CODE_W    = 2;

    localparam logic [STICK_W-1:0] STICK_LIMIT = 7'd100;
    localparam logic [STICK_W-1:0] NEUTRAL     = 7'd50;
    localparam logic [PULSE_W-1:0] PULSE_LIMIT = 12'd4095;

    localparam logic [HOLD_W-1:0]  ARM_HOLD_RESET    = 16'd5000;
    localparam logic [HOLD_W-1:0]  DISARM_HOLD_RESET = 16'd3000;
    localparam logic [PULSE_W-1:0] PULSE_MIN_RESET   = 12'd1000;
    localparam logic [PULSE_W-1:0] PULSE_MAX_RESET   = 12'd2000;
    localparam logic [GAIN_W-1:0]  GAIN_RESET        = 6'd10;
    localparam logic [PULSE_W-1:0] CENTER_WIDTH_RESET   = 12'd1500;
    localparam logic [PULSE_W-1:0] THROTTLE_WIDTH_RESET = 12'd1000;

    localparam logic [CODE_W-1:0] ARM_CODE_DISARMED  = 2'd0;
    localparam logic [CODE_W-1:0] ARM_CODE_ARMING    = 2'd1;
    localparam logic [CODE_W-1:0] ARM_CODE_ARMED     = 2'd2;
    localparam logic [CODE_W-1:0] ARM_CODE_DISARMING = 2'd3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ARM_HOLD    = 3'd0,
        REG_DISARM_HOLD = 3'd1,
        REG_PULSE_MIN   = 3'd2,
        REG_PULSE_MAX   = 3'd3,
        REG_STICK_GAIN  = 3'd4
    } cfg_reg_t;

    typedef enum logic [3:0] {
        MODE_DISARMED  = 4'b0001,
        MODE_ARMING    = 4'b0010,
        MODE_ARMED     = 4'b0100,
        MODE_DISARMING = 4'b1000
    } mode_t;

    typedef struct packed {
        logic [HOLD_W-1:0]  arm_hold_ms;
        logic [HOLD_W-1:0]  disarm_hold_ms;
        logic [PULSE_W-1:0] pulse_min_us;
        logic [PULSE_W-1:0] pulse_max_us;
        logic [GAIN_W-1:0]  stick_gain;
    } cfg_t;

    typedef struct packed {
        logic [ELAPSED_W-1:0] elapsed_ms;
        logic                 arm_switch;
        logic [STICK_W-1:0]   stick_roll;
        logic [STICK_W-1:0]   stick_pitch;
        logic [STICK_W-1:0]   stick_yaw;
        logic [STICK_W-1:0]   stick_throttle;
        logic                 avoid_on;
        logic [STICK_W-1:0]   comp_roll;
        logic [STICK_W-1:0]   comp_pitch;
    } item_t;

    typedef struct packed {
        logic [PULSE_W-1:0]       roll_pulse_us;
        logic [PULSE_W-1:0]       pitch_pulse_us;
        logic [PULSE_W-1:0]       yaw_pulse_us;
        logic [PULSE_W-1:0]       throttle_pulse_us;
        logic [CODE_W-1:0]        arm_mode;
        logic signed [MIX_W-1:0]  total_roll;
        logic signed [MIX_W-1:0]  total_pitch;
        logic [STICK_W-1:0]       joy_roll;
        logic [STICK_W-1:0]       joy_pitch;
    } result_t;

    function automatic logic [STICK_W-1:0] clamp_stick(input logic [STICK_W-1:0] v);
        clamp_stick = (v > STICK_LIMIT) ? STICK_LIMIT : v;
    endfunction

    function automatic logic [CODE_W-1:0] mode_code(input mode_t m);
        logic [CODE_W-1:0] code;
        unique case (m)
            MODE_DISARMED:  code = ARM_CODE_DISARMED;
            MODE_ARMING:    code = ARM_CODE_ARMING;
            MODE_ARMED:     code = ARM_CODE_ARMED;
            MODE_DISARMING: code = ARM_CODE_DISARMING;
            default:        code = ARM_CODE_DISARMED;
        endcase
        mode_code = code;
    endfunction

    function automatic logic [PULSE_W-1:0] scale_pulse(
        input logic signed [MIX_W-1:0] value,
        input logic [GAIN_W-1:0]       gain,
        input logic [PULSE_W-1:0]      pmin
    );
        logic signed [15:0] v16;
        logic signed [15:0] g16;
        logic signed [15:0] prod;
        logic signed [15:0] sum;
        v16  = 16'(value);
        g16  = {10'd0, gain};
        prod = v16 * g16;
        sum  = prod + signed'({4'd0, pmin});
        if (sum < 0)
        begin
            scale_pulse = '0;
        end
        else if (sum > signed'({4'd0, PULSE_LIMIT}))
        begin
            scale_pulse = PULSE_LIMIT;
        end
        else
        begin
            scale_pulse = sum[PULSE_W-1:0];
        end
    endfunction

endpackage

// ===== sv/rc_arming_sequencer_stick_mixer.sv =====
// Top level of the RC arming sequencer and stick mixer.
// Each control step item passes through an input register, the mixing and sequencing
// logic, and a result register. A result is presented on the master side once its item
// has been loaded from the input register into the result register, and a new item is
// taken every cycle while the result side keeps up. The sequencer state (mode, hold
// timer, held pulse widths) is updated as each item passes the mixing and sequencing
// logic, which sets the one-item-per-cycle rate. Configuration writes take effect
// at the next clock edge and should be made while no item is in flight.
module rc_arming_sequencer_stick_mixer (
    input  logic                                clk,
    input  logic                                rst_n,
    // Fields from bit 0 up: elapsed_ms, arm_switch, stick_roll, stick_pitch, stick_yaw,
    // stick_throttle, avoid_on, comp_roll, comp_pitch, zero padding.
    input  logic [rasm_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // Fields from bit 0 up: roll_pulse_us, pitch_pulse_us, yaw_pulse_us,
    // throttle_pulse_us, arm_mode, total_roll, total_pitch, joy_roll, joy_pitch,
    // zero padding.
    output logic [rasm_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_we,
    input  logic [rasm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rasm_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import rasm_pkg::*;

    cfg_t    cfg;
    item_t   item;
    result_t result;
    logic    in_valid;
    logic    advance;
    logic    fire;

    logic                   out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    assign advance = !out_valid_reg || m_tready;
    assign fire    = in_valid && advance;

    rasm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rasm_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .advance  (advance),
        .valid    (in_valid),
        .item     (item)
    );

    rasm_step u_step (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item),
        .cfg    (cfg),
        .result (result)
    );

    always_comb
    begin
        out_data_next        = '0;
        out_data_next[11:0]  = result.roll_pulse_us;
        out_data_next[23:12] = result.pitch_pulse_us;
        out_data_next[35:24] = result.yaw_pulse_us;
        out_data_next[47:36] = result.throttle_pulse_us;
        out_data_next[49:48] = result.arm_mode;
        out_data_next[58:50] = result.total_roll;
        out_data_next[67:59] = result.total_pitch;
        out_data_next[74:68] = result.joy_roll;
        out_data_next[81:75] = result.joy_pitch;
    end

    always_comb
    begin
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    a_full_stall_blocks_input: assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready && in_valid) |-> !s_tready
    ) else $error("input accepted while both stages are full and stalled");

    a_fire_loads_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        fire |=> m_tvalid
    ) else $error("processed item did not produce a valid result");

    a_neutral_when_not_armed: assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[49:48] == ARM_CODE_DISARMED
                      || m_tdata[49:48] == ARM_CODE_ARMING))
        |-> (m_tdata[74:68] == NEUTRAL && m_tdata[81:75] == NEUTRAL)
    ) else $error("joystick values not neutral outside armed states");
`endif

endmodule

// ===== sv/rasm_cfg.sv =====
// Configuration register bank for hold times, pulse limits and stick gain.
module rasm_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [rasm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [rasm_pkg::CFG_DATA_W-1:0]    cfg_data,
    output rasm_pkg::cfg_t                     cfg
);
    import rasm_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ARM_HOLD:    cfg_next.arm_hold_ms    = cfg_data;
                REG_DISARM_HOLD: cfg_next.disarm_hold_ms = cfg_data;
                REG_PULSE_MIN:   cfg_next.pulse_min_us   = cfg_data[PULSE_W-1:0];
                REG_PULSE_MAX:   cfg_next.pulse_max_us   = cfg_data[PULSE_W-1:0];
                REG_STICK_GAIN:  cfg_next.stick_gain     = cfg_data[GAIN_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.arm_hold_ms    <= ARM_HOLD_RESET;
            cfg_reg.disarm_hold_ms <= DISARM_HOLD_RESET;
            cfg_reg.pulse_min_us   <= PULSE_MIN_RESET;
            cfg_reg.pulse_max_us   <= PULSE_MAX_RESET;
            cfg_reg.stick_gain     <= GAIN_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/rasm_in_stage.sv =====
// Input register that unpacks and clamps one control step item.
module rasm_in_stage (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rasm_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic                              advance,
    output logic                              valid,
    output rasm_pkg::item_t                   item
);
    import rasm_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    item_t item_next;
    logic  accept;

    assign s_tready = !valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        item_next.elapsed_ms     = s_tdata[9:0];
        item_next.arm_switch     = s_tdata[10];
        item_next.stick_roll     = clamp_stick(s_tdata[17:11]);
        item_next.stick_pitch    = clamp_stick(s_tdata[24:18]);
        item_next.stick_yaw      = clamp_stick(s_tdata[31:25]);
        item_next.stick_throttle = clamp_stick(s_tdata[38:32]);
        item_next.avoid_on       = s_tdata[39];
        item_next.comp_roll      = clamp_stick(s_tdata[46:40]);
        item_next.comp_pitch     = clamp_stick(s_tdata[53:47]);
    end

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

    assign valid = valid_reg;
    assign item  = item_reg;

endmodule

// ===== sv/rasm_step.sv =====
// Arming sequence state, hold timer and stick mixing for one control step per cycle while fire is high.
module rasm_step (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  rasm_pkg::item_t   item,
    input  rasm_pkg::cfg_t    cfg,
    output rasm_pkg::result_t result
);
    import rasm_pkg::*;

    mode_t                     mode_reg, mode_next;
    logic [HOLD_W-1:0]         hold_reg, hold_next;
    logic [PULSE_W-1:0]        roll_w_reg, roll_w_next;
    logic [PULSE_W-1:0]        pitch_w_reg, pitch_w_next;
    logic [PULSE_W-1:0]        yaw_w_reg, yaw_w_next;
    logic [PULSE_W-1:0]        thr_w_reg, thr_w_next;
    logic signed [MIX_W-1:0]   mix_roll_reg, mix_roll_next;
    logic signed [MIX_W-1:0]   mix_pitch_reg, mix_pitch_next;
    logic [STICK_W-1:0]        joy_roll_reg, joy_roll_next;
    logic [STICK_W-1:0]        joy_pitch_reg, joy_pitch_next;

    logic [PULSE_W:0]          pulse_sum;
    logic [PULSE_W-1:0]        center;
    logic [HOLD_W-1:0]         elapsed_ext;
    logic [HOLD_W-1:0]         hold_dec;
    logic [MIX_W-1:0]          mix_r;
    logic [MIX_W-1:0]          mix_p;

    assign pulse_sum   = {1'b0, cfg.pulse_min_us} + {1'b0, cfg.pulse_max_us};
    assign center      = pulse_sum[PULSE_W:1];
    assign elapsed_ext = {{(HOLD_W-ELAPSED_W){1'b0}}, item.elapsed_ms};
    assign hold_dec    = (hold_reg > elapsed_ext) ? (hold_reg - elapsed_ext) : '0;

    always_comb
    begin
        mix_r = {2'b00, item.stick_roll};
        mix_p = {2'b00, item.stick_pitch};
        if (item.avoid_on)
        begin
            mix_r = mix_r + {2'b00, item.comp_roll} - {2'b00, NEUTRAL};
            mix_p = mix_p + {2'b00, item.comp_pitch} - {2'b00, NEUTRAL};
        end
    end

    always_comb
    begin
        mode_next      = mode_reg;
        hold_next      = hold_dec;
        roll_w_next    = roll_w_reg;
        pitch_w_next   = pitch_w_reg;
        yaw_w_next     = yaw_w_reg;
        thr_w_next     = thr_w_reg;
        mix_roll_next  = mix_roll_reg;
        mix_pitch_next = mix_pitch_reg;
        joy_roll_next  = joy_roll_reg;
        joy_pitch_next = joy_pitch_reg;

        // A finished hold moves the sequence on before the switch is looked at.
        if ((mode_reg == MODE_ARMING || mode_reg == MODE_DISARMING) && hold_dec == '0)
        begin
            mode_next    = (mode_reg == MODE_ARMING) ? MODE_ARMED : MODE_DISARMED;
            roll_w_next  = center;
            pitch_w_next = center;
            yaw_w_next   = center;
            thr_w_next   = cfg.pulse_min_us;
        end

        if (mode_next == MODE_DISARMED && item.arm_switch)
        begin
            hold_next    = cfg.arm_hold_ms;
            mode_next    = MODE_ARMING;
            roll_w_next  = center;
            pitch_w_next = center;
            yaw_w_next   = cfg.pulse_max_us;
            thr_w_next   = cfg.pulse_min_us;
        end
        else if (mode_next == MODE_ARMED && !item.arm_switch)
        begin
            hold_next      = cfg.disarm_hold_ms;
            mode_next      = MODE_DISARMING;
            roll_w_next    = center;
            pitch_w_next   = center;
            yaw_w_next     = cfg.pulse_min_us;
            thr_w_next     = cfg.pulse_min_us;
            mix_roll_next  = signed'({2'b00, NEUTRAL});
            mix_pitch_next = signed'({2'b00, NEUTRAL});
            joy_roll_next  = NEUTRAL;
            joy_pitch_next = NEUTRAL;
        end

        if (mode_next == MODE_ARMED)
        begin
            joy_roll_next  = item.stick_roll;
            joy_pitch_next = item.stick_pitch;
            mix_roll_next  = signed'(mix_r);
            mix_pitch_next = signed'(mix_p);
            roll_w_next    = scale_pulse(signed'(mix_r), cfg.stick_gain, cfg.pulse_min_us);
            pitch_w_next   = scale_pulse(signed'(mix_p), cfg.stick_gain, cfg.pulse_min_us);
            yaw_w_next     = scale_pulse(signed'({2'b00, item.stick_yaw}),
                                         cfg.stick_gain, cfg.pulse_min_us);
            thr_w_next     = scale_pulse(signed'({2'b00, item.stick_throttle}),
                                         cfg.stick_gain, cfg.pulse_min_us);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_DISARMED;
            hold_reg      <= '0;
            roll_w_reg    <= CENTER_WIDTH_RESET;
            pitch_w_reg   <= CENTER_WIDTH_RESET;
            yaw_w_reg     <= CENTER_WIDTH_RESET;
            thr_w_reg     <= THROTTLE_WIDTH_RESET;
            mix_roll_reg  <= signed'({2'b00, NEUTRAL});
            mix_pitch_reg <= signed'({2'b00, NEUTRAL});
            joy_roll_reg  <= NEUTRAL;
            joy_pitch_reg <= NEUTRAL;
        end
        else if (fire)
        begin
            mode_reg      <= mode_next;
            hold_reg      <= hold_next;
            roll_w_reg    <= roll_w_next;
            pitch_w_reg   <= pitch_w_next;
            yaw_w_reg     <= yaw_w_next;
            thr_w_reg     <= thr_w_next;
            mix_roll_reg  <= mix_roll_next;
            mix_pitch_reg <= mix_pitch_next;
            joy_roll_reg  <= joy_roll_next;
            joy_pitch_reg <= joy_pitch_next;
        end
    end

    always_comb
    begin
        result.roll_pulse_us     = roll_w_next;
        result.pitch_pulse_us    = pitch_w_next;
        result.yaw_pulse_us      = yaw_w_next;
        result.throttle_pulse_us = thr_w_next;
        result.arm_mode          = mode_code(mode_next);
        result.total_roll        = mix_roll_next;
        result.total_pitch       = mix_pitch_next;
        result.joy_roll          = joy_roll_next;
        result.joy_pitch         = joy_pitch_next;
    end

endmodule
